// ===== design/pal_pkg.sv =====
// Shared types and constants of the positional array list.
package pal_pkg;

  // Fixed widths of the word fields.
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_UPDATE = 3'd2,
    CMD_READ   = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e;

  // Status codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // Operation broadcast along the cell row.
  typedef enum logic [1:0] {
    CELL_INSERT = 2'd0,
    CELL_DELETE = 2'd1,
    CELL_UPDATE = 2'd2,
    CELL_CLEAR  = 2'd3
  } cell_op_e;

  // Control word that every cell sees in the same cycle.
  typedef struct packed {
    logic             en;
    cell_op_e         op;
    logic [POS_W-1:0] slot;
  } cell_ctrl_t;

endpackage

// ===== design/pal_in_if.sv =====
// Command channel of the positional array list.
interface pal_in_if;
  logic                        valid;
  logic                        ready;
  logic [pal_pkg::CMD_W-1:0]   cmd;
  logic [pal_pkg::POS_W-1:0]   position;
  logic [pal_pkg::VALUE_W-1:0] value;

  modport source (output valid, output cmd, output position, output value, input ready);
  modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

// ===== design/pal_out_if.sv =====
// Result channel of the positional array list.
interface pal_out_if;
  logic                         valid;
  logic                         ready;
  logic [pal_pkg::STATUS_W-1:0] status;
  logic [pal_pkg::VALUE_W-1:0]  element;
  logic [pal_pkg::COUNT_W-1:0]  count;

  modport source (output valid, output status, output element, output count, input ready);
  modport sink   (input valid, input status, input element, input count, output ready);
endinterface

// ===== design/pal_cell.sv =====
// One storage cell of the list: holds one entry and trades it with its neighbors.
module pal_cell #(
  parameter int unsigned INDEX  = 0,
  parameter int unsigned DATA_W = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pal_pkg::cell_ctrl_t ctrl_i,
  input  logic [DATA_W-1:0]   value_i,
  input  logic [DATA_W-1:0]   left_i,
  input  logic [DATA_W-1:0]   right_i,
  output logic [DATA_W-1:0]   data_o,
  output logic [DATA_W-1:0]   read_o
);
  import pal_pkg::*;

  // Own place compared with the selected slot; places past the slot field are always above.
  localparam bit               INDEX_HIGH = (INDEX >= (1 << POS_W));
  localparam logic [POS_W-1:0] INDEX_LO   = POS_W'(INDEX % (1 << POS_W));

  logic              at_slot;
  logic              above_slot;
  logic [DATA_W-1:0] data_d;
  logic [DATA_W-1:0] data_q;

  assign at_slot    = !INDEX_HIGH && (INDEX_LO == ctrl_i.slot);
  assign above_slot = INDEX_HIGH || (INDEX_LO > ctrl_i.slot);

  // Next entry: load, take from a neighbor, clear or hold.
  always_comb begin
    data_d = data_q;
    if (ctrl_i.en) begin
      case (ctrl_i.op)
        CELL_INSERT: begin
          if (at_slot) begin
            data_d = value_i;
          end else if (above_slot) begin
            data_d = left_i;
          end
        end
        CELL_DELETE: begin
          if (at_slot || above_slot) begin
            data_d = right_i;
          end
        end
        CELL_UPDATE: begin
          if (at_slot) begin
            data_d = value_i;
          end
        end
        CELL_CLEAR: begin
          data_d = '0;
        end
        default: begin
          data_d = data_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;
  // Only the selected cell drives its entry onto the read bus.
  assign read_o = at_slot ? data_q : '0;

endmodule

// ===== design/positional_array_list.sv =====
// Positional array list: a row of entry cells with a shared command decoder.
// Each result word is registered and appears in the cycle after its command word is accepted.
// Throughput: one command word per cycle while each result word is taken; every cell shifts in parallel.
// The result register frees the input as soon as its word is taken.
// Reset clears every entry to zero and the length to zero, at once.
module positional_array_list #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  pal_in_if.sink           in_i,
  pal_out_if.source        out_o
);
  import pal_pkg::*;

  // Entries keep no more bits than the value field carries.
  localparam int unsigned DATA_W = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;
  localparam int unsigned FILL_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W  = ((FILL_W > POS_W) ? FILL_W : POS_W) + 1;

  logic [FILL_W-1:0] fill_q;
  logic [FILL_W-1:0] fill_d;
  logic              accept;
  logic [CMP_W-1:0]  pos_c;
  logic [CMP_W-1:0]  fill_c;
  logic              pos_zero;
  logic              ins_bad;
  logic              acc_bad;
  logic              full;
  logic [DATA_W-1:0] value_m;
  logic [DATA_W-1:0] sel_data;
  cell_ctrl_t        ctrl;
  status_e           status_d;
  logic              take_elem;
  logic [DATA_W-1:0] element_d;

  logic                out_valid_q;
  logic [STATUS_W-1:0] status_q;
  logic [VALUE_W-1:0]  element_q;
  logic [COUNT_W-1:0]  count_q;

  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] cell_read [CAPACITY];

  // Handshake on the command side.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // Position checks against the current length.
  assign pos_c    = CMP_W'(in_i.position);
  assign fill_c   = CMP_W'(fill_q);
  assign pos_zero = (in_i.position == '0);
  assign ins_bad  = pos_zero || (pos_c > (fill_c + CMP_W'(1)));
  assign acc_bad  = pos_zero || (pos_c > fill_c);
  assign full     = (fill_q == FILL_W'(CAPACITY));
  assign value_m  = DATA_W'(in_i.value);

  // Command decode into the broadcast control word and the result.
  always_comb begin
    ctrl.en   = 1'b0;
    ctrl.op   = CELL_UPDATE;
    ctrl.slot = in_i.position - POS_W'(1);
    status_d  = STATUS_OK;
    take_elem = 1'b0;
    fill_d    = fill_q;
    case (in_i.cmd)
      CMD_INSERT: begin
        if (ins_bad) begin
          status_d = STATUS_RANGE;
        end else if (full) begin
          status_d = STATUS_FULL;
        end else begin
          ctrl.en = accept;
          ctrl.op = CELL_INSERT;
          fill_d  = fill_q + FILL_W'(1);
        end
      end
      CMD_DELETE: begin
        if (acc_bad) begin
          status_d = STATUS_RANGE;
        end else begin
          ctrl.en   = accept;
          ctrl.op   = CELL_DELETE;
          take_elem = 1'b1;
          fill_d    = fill_q - FILL_W'(1);
        end
      end
      CMD_UPDATE: begin
        if (acc_bad) begin
          status_d = STATUS_RANGE;
        end else begin
          ctrl.en = accept;
          ctrl.op = CELL_UPDATE;
        end
      end
      CMD_READ: begin
        if (acc_bad) begin
          status_d = STATUS_RANGE;
        end else begin
          take_elem = 1'b1;
        end
      end
      CMD_CLEAR: begin
        ctrl.en = accept;
        ctrl.op = CELL_CLEAR;
        fill_d  = '0;
      end
      default: begin
        status_d = STATUS_OK;
      end
    endcase
  end

  // Returned entry: the selected cell for a good delete or read, else zero.
  assign element_d = take_elem ? sel_data : '0;

  // The row of cells; the top cell pulls in zero on a delete.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [DATA_W-1:0] left_w;
    logic [DATA_W-1:0] right_w;

    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[k+1];
    end

    pal_cell #(
      .INDEX  (k),
      .DATA_W (DATA_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .value_i (value_m),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[k]),
      .read_o  (cell_read[k])
    );
  end

  // Read bus: at most one cell drives a nonzero entry.
  always_comb begin
    sel_data = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      sel_data = sel_data | cell_read[k];
    end
  end

  // Length and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
      status_q    <= '0;
      element_q   <= '0;
      count_q     <= '0;
    end else begin
      if (accept) begin
        fill_q      <= fill_d;
        out_valid_q <= 1'b1;
        status_q    <= status_d;
        element_q   <= VALUE_W'(element_d);
        count_q     <= COUNT_W'(fill_d);
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.status  = status_q;
  assign out_o.element = element_q;
  assign out_o.count   = count_q;

endmodule
